/* src/lz_range_coded_decompressor_assert.svh */
// Assertion macros shared by the RTL of the range-coded LZ decompressor.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef LZ_RANGE_CODED_DECOMPRESSOR_ASSERT_SVH
`define LZ_RANGE_CODED_DECOMPRESSOR_ASSERT_SVH
`ifndef ASSERT_OFF
// Property that must hold at every clock edge outside reset.
`define LZRC_ASSERT(label, clk_s, rst_s, prop) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
        else $error("lzrc assertion failed");
// Condition that must never be seen outside reset.
`define LZRC_NEVER(label, clk_s, rst_s, cond) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond)) \
        else $error("lzrc forbidden condition seen");
`else
`define LZRC_ASSERT(label, clk_s, rst_s, prop)
`define LZRC_NEVER(label, clk_s, rst_s, cond)
`endif
`endif

/* src/lzrc_pkg.sv */
// Shared constants, status codes and interface structs of the decompressor.
// Used by the symbol decoder and the top level.
package lzrc_pkg;

    localparam int CTX_COUNT  = 256;
    localparam int FREQ_DEPTH = 65536;
    localparam int WIN_DEPTH  = 65536;
    localparam int WIN_AW     = 16;

    localparam logic [31:0] TOP_LIMIT      = 32'h0100_0000;
    localparam logic [31:0] BOTTOM_LIMIT   = 32'h0001_0000;
    localparam logic [15:0] END_OFFSET     = 16'h0100;
    localparam logic [15:0] COPY_BIAS      = 16'd259;
    localparam logic [8:0]  MIN_RUN        = 9'd4;
    localparam logic [15:0] CTX_TOTAL_INIT = 16'd256;
    localparam logic [15:0] FREQ_INIT      = 16'd1;
    localparam logic [7:0]  WIN_INIT       = 8'hff;
    localparam logic [7:0]  FLAG_FULL      = 8'hff;
    localparam logic [2:0]  PRELOAD_BYTES  = 3'd4;

    localparam logic OP_FEED    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    typedef enum logic [2:0] {
        ST_TAKEN   = 3'd0,
        ST_BYTE    = 3'd1,
        ST_NEED    = 3'd2,
        ST_END     = 3'd3,
        ST_ERROR   = 3'd4,
        ST_REFUSED = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0]  ctx;
        logic [31:0] width;
        logic [31:0] low;
        logic [31:0] code;
    } dec_req_t;

    typedef struct packed {
        logic        ok;
        logic [7:0]  sym;
        logic [31:0] low;
        logic [31:0] width;
    } dec_res_t;

endpackage

/* src/lz_range_coded_decompressor.sv */
// Range-coded LZ decompressor: feed words take one compressed byte, request words
// return one decompressed byte or a status. After reset a clearing pass over all 65536
// addresses fills the window, frequency and total memories; no word is accepted meanwhile.
// A request from the window is served by a window read; each decoded symbol goes through
// two serial divisions and a search on the frequency memory port, and a rescale pass
// over the context's counts when its total wraps.
`include "lz_range_coded_decompressor_assert.svh"
module lz_range_coded_decompressor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [0:0]  s_axis_tuser,   // [0] opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]  m_axis_tuser    // [2:0] status
);
    import lzrc_pkg::*;

    // Top-level sequencer. LOOP walks the LZ record structure: pending copy bytes first,
    // then a need-input reply if normalization is due, then the next flag-driven record, then a new flag byte.
    typedef enum logic [5:0] {
        T_CLEAR = 6'b000001,
        T_IDLE  = 6'b000010,
        T_LOOP  = 6'b000100,
        T_WRD   = 6'b001000,
        T_CTXRD = 6'b010000,
        T_DEC   = 6'b100000
    } tstate_t;

    // Which kind of symbol the decoder is working on.
    typedef enum logic [2:0] {
        K_FLAG  = 3'b001,
        K_LIT   = 3'b010,
        K_FIELD = 3'b100
    } kind_t;

    logic [7:0] win_mem [WIN_DEPTH];

    tstate_t     state_reg, state_next;
    kind_t       kind_reg, kind_next;
    logic [15:0] clr_reg, clr_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] code_reg, code_next;
    logic [31:0] width_reg, width_next;
    logic [2:0]  preload_count_reg, preload_count_next;
    logic [7:0]  flag_bits_reg, flag_bits_next;
    logic [7:0]  flag_mask_reg, flag_mask_next;
    logic [7:0]  mf0_reg, mf0_next;
    logic [7:0]  mf1_reg, mf1_next;
    logic [1:0]  field_phase_reg, field_phase_next;
    logic [8:0]  copy_count_reg, copy_count_next;
    logic [15:0] copy_source_reg, copy_source_next;
    logic        run_mode_reg, run_mode_next;
    logic [15:0] write_pos_reg, write_pos_next;
    logic        ended_reg, ended_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg, out_byte_next;
    status_t     out_status_reg, out_status_next;

    logic              win_we;
    logic [WIN_AW-1:0] win_wa, win_ra;
    logic [7:0]        win_wd, win_rdata;

    logic     dec_start, dec_done;
    dec_req_t dec_req;
    dec_res_t dec_res;

    logic        in_fire;
    logic        norm_pending;
    logic [31:0] low_sh, width_sh, sum_sh;
    logic [15:0] offset;

    assign in_fire = s_axis_tvalid && s_axis_tready;

    // Normalization is due when the code falls below low, the top bytes of both
    // interval ends agree, or the width has shrunk below 16 bits.
    assign norm_pending = (code_reg < low_reg)
                       || ((low_reg ^ (low_reg + width_reg)) < TOP_LIMIT)
                       || (width_reg < BOTTOM_LIMIT);

    assign low_sh   = {low_reg[23:0], 8'd0};
    assign width_sh = {width_reg[23:0], 8'd0};
    assign sum_sh   = width_sh + low_sh;
    assign offset   = {dec_res.sym, mf1_reg};

    lzrc_sym_dec u_sym_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_en   (state_reg == T_CLEAR),
        .clear_addr (clr_reg),
        .start      (dec_start),
        .req        (dec_req),
        .done       (dec_done),
        .res        (dec_res)
    );

    always_comb
    begin
        state_next         = state_reg;
        kind_next          = kind_reg;
        clr_next           = clr_reg;
        low_next           = low_reg;
        code_next          = code_reg;
        width_next         = width_reg;
        preload_count_next = preload_count_reg;
        flag_bits_next     = flag_bits_reg;
        flag_mask_next     = flag_mask_reg;
        mf0_next           = mf0_reg;
        mf1_next           = mf1_reg;
        field_phase_next   = field_phase_reg;
        copy_count_next    = copy_count_reg;
        copy_source_next   = copy_source_reg;
        run_mode_next      = run_mode_reg;
        write_pos_next     = write_pos_reg;
        ended_next         = ended_reg;
        out_valid_next     = out_valid_reg && !m_axis_tready;
        out_byte_next      = out_byte_reg;
        out_status_next    = out_status_reg;
        win_we             = 1'b0;
        win_wa             = write_pos_reg;
        win_wd             = win_rdata;
        win_ra             = copy_source_reg;
        dec_start          = 1'b0;
        dec_req.ctx        = 8'd0;
        dec_req.width      = width_reg;
        dec_req.low        = low_reg;
        dec_req.code       = code_reg;

        unique case (state_reg)
            T_CLEAR:
            begin
                win_we   = 1'b1;
                win_wa   = clr_reg;
                win_wd   = WIN_INIT;
                clr_next = clr_reg + 16'd1;
                if (clr_reg == 16'hffff)
                begin
                    state_next = T_IDLE;
                end
            end
            T_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = 8'd0;
                    if (s_axis_tuser[0] == OP_FEED)
                    begin
                        if (preload_count_reg < PRELOAD_BYTES)
                        begin
                            code_next          = {code_reg[23:0], s_axis_tdata};
                            preload_count_next = preload_count_reg + 3'd1;
                            out_status_next    = ST_TAKEN;
                        end
                        else if (ended_reg || !norm_pending)
                        begin
                            out_status_next = ST_REFUSED;
                        end
                        else
                        begin
                            // Shift in one byte; clamp the width if the top end wraps.
                            code_next       = {code_reg[23:0], s_axis_tdata};
                            low_next        = low_sh;
                            width_next      = (sum_sh < low_sh) ? ~low_sh : width_sh;
                            out_status_next = ST_TAKEN;
                        end
                    end
                    else if (ended_reg)
                    begin
                        out_status_next = ST_END;
                    end
                    else if (preload_count_reg < PRELOAD_BYTES)
                    begin
                        out_status_next = ST_NEED;
                    end
                    else
                    begin
                        out_valid_next = 1'b0;
                        state_next     = T_LOOP;
                    end
                end
            end
            T_LOOP:
            begin
                priority if (copy_count_reg != 9'd0)
                begin
                    if (run_mode_reg)
                    begin
                        win_we          = 1'b1;
                        win_wd          = copy_source_reg[7:0];
                        write_pos_next  = write_pos_reg + 16'd1;
                        copy_count_next = copy_count_reg - 9'd1;
                        out_valid_next  = 1'b1;
                        out_byte_next   = copy_source_reg[7:0];
                        out_status_next = ST_BYTE;
                        state_next      = T_IDLE;
                    end
                    else
                    begin
                        state_next = T_WRD;
                    end
                end
                else if (norm_pending)
                begin
                    // Any symbol decode needs a normalized range first.
                    out_valid_next  = 1'b1;
                    out_byte_next   = 8'd0;
                    out_status_next = ST_NEED;
                    state_next      = T_IDLE;
                end
                else if (flag_mask_reg != 8'd0 && flag_bits_reg[7])
                begin
                    // A literal is coded in the context of the last output byte.
                    win_ra     = write_pos_reg - 16'd1;
                    state_next = T_CTXRD;
                end
                else if (flag_mask_reg != 8'd0)
                begin
                    dec_start   = 1'b1;
                    dec_req.ctx = {6'd0, field_phase_reg} + 8'd1;
                    kind_next   = K_FIELD;
                    state_next  = T_DEC;
                end
                else
                begin
                    dec_start   = 1'b1;
                    dec_req.ctx = 8'd0;
                    kind_next   = K_FLAG;
                    state_next  = T_DEC;
                end
            end
            T_WRD:
            begin
                win_we           = 1'b1;
                win_wd           = win_rdata;
                write_pos_next   = write_pos_reg + 16'd1;
                copy_source_next = copy_source_reg + 16'd1;
                copy_count_next  = copy_count_reg - 9'd1;
                out_valid_next   = 1'b1;
                out_byte_next    = win_rdata;
                out_status_next  = ST_BYTE;
                state_next       = T_IDLE;
            end
            T_CTXRD:
            begin
                dec_start   = 1'b1;
                dec_req.ctx = win_rdata;
                kind_next   = K_LIT;
                state_next  = T_DEC;
            end
            T_DEC:
            begin
                if (dec_done)
                begin
                    width_next = dec_res.width;
                    if (!dec_res.ok)
                    begin
                        if (kind_reg == K_FIELD)
                        begin
                            field_phase_next = 2'd0;
                        end
                        out_valid_next  = 1'b1;
                        out_byte_next   = 8'd0;
                        out_status_next = ST_ERROR;
                        state_next      = T_IDLE;
                    end
                    else
                    begin
                        low_next   = dec_res.low;
                        state_next = T_LOOP;
                        unique case (kind_reg)
                            K_FLAG:
                            begin
                                flag_bits_next = dec_res.sym;
                                flag_mask_next = FLAG_FULL;
                            end
                            K_LIT:
                            begin
                                copy_source_next = {copy_source_reg[15:8], dec_res.sym};
                                copy_count_next  = 9'd1;
                                run_mode_next    = 1'b1;
                                flag_bits_next   = {flag_bits_reg[6:0], 1'b0};
                                flag_mask_next   = {flag_mask_reg[6:0], 1'b0};
                            end
                            K_FIELD:
                            begin
                                if (field_phase_reg == 2'd0)
                                begin
                                    mf0_next         = dec_res.sym;
                                    field_phase_next = 2'd1;
                                end
                                else if (field_phase_reg == 2'd1)
                                begin
                                    mf1_next         = dec_res.sym;
                                    field_phase_next = 2'd2;
                                end
                                else
                                begin
                                    // Third field completes the match record.
                                    field_phase_next = 2'd0;
                                    run_mode_next    = 1'b1;
                                    if (offset == END_OFFSET)
                                    begin
                                        copy_count_next  = 9'd0;
                                        copy_source_next = offset;
                                        ended_next       = 1'b1;
                                        out_valid_next   = 1'b1;
                                        out_byte_next    = 8'd0;
                                        out_status_next  = ST_END;
                                        state_next       = T_IDLE;
                                    end
                                    else
                                    begin
                                        copy_count_next = MIN_RUN + {1'b0, mf0_reg};
                                        if (offset > END_OFFSET)
                                        begin
                                            copy_source_next = ~offset + write_pos_reg
                                                             + COPY_BIAS;
                                            run_mode_next    = 1'b0;
                                        end
                                        else
                                        begin
                                            copy_source_next = offset;
                                        end
                                        flag_bits_next = {flag_bits_reg[6:0], 1'b0};
                                        flag_mask_next = {flag_mask_reg[6:0], 1'b0};
                                    end
                                end
                            end
                            default:
                            begin
                                state_next = T_LOOP;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[win_wa] <= win_wd;
        end
        win_rdata <= win_mem[win_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= T_CLEAR;
            kind_reg          <= K_FLAG;
            clr_reg           <= 16'd0;
            low_reg           <= 32'd0;
            code_reg          <= 32'd0;
            width_reg         <= 32'hffff_ffff;
            preload_count_reg <= 3'd0;
            flag_bits_reg     <= 8'd0;
            flag_mask_reg     <= 8'd0;
            mf0_reg           <= 8'd0;
            mf1_reg           <= 8'd0;
            field_phase_reg   <= 2'd0;
            copy_count_reg    <= 9'd0;
            copy_source_reg   <= 16'hffff;
            run_mode_reg      <= 1'b0;
            write_pos_reg     <= 16'd0;
            ended_reg         <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            kind_reg          <= kind_next;
            clr_reg           <= clr_next;
            low_reg           <= low_next;
            code_reg          <= code_next;
            width_reg         <= width_next;
            preload_count_reg <= preload_count_next;
            flag_bits_reg     <= flag_bits_next;
            flag_mask_reg     <= flag_mask_next;
            mf0_reg           <= mf0_next;
            mf1_reg           <= mf1_next;
            field_phase_reg   <= field_phase_next;
            copy_count_reg    <= copy_count_next;
            copy_source_reg   <= copy_source_next;
            run_mode_reg      <= run_mode_next;
            write_pos_reg     <= write_pos_next;
            ended_reg         <= ended_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
    end

    // A new word is taken only when idle and the output register is empty.
    assign s_axis_tready = (state_reg == T_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_status_reg;

    `LZRC_ASSERT(a_preload_bound, clk, rst_n, preload_count_reg <= PRELOAD_BYTES)
    `LZRC_ASSERT(a_copy_bound, clk, rst_n, copy_count_reg <= 9'd259)
    `LZRC_NEVER(a_accept_in_clear, clk, rst_n, (state_reg == T_CLEAR) && s_axis_tready)
    `LZRC_ASSERT(a_dec_done_waited, clk, rst_n, dec_done |-> (state_reg == T_DEC))
    `LZRC_NEVER(a_phase_three, clk, rst_n, field_phase_reg == 2'd3)
endmodule

/* src/lzrc_div.sv */
// Restoring 32-bit by 32-bit divider, one quotient bit per cycle.
// Depends on nothing; the divisor must be nonzero.
module lzrc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] shifted;
    logic [33:0] diff;

    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = {1'b0, shifted} - {2'b00, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so 32 bits hold it.
            rem_next = diff[33] ? shifted[31:0] : diff[31:0];
            quo_next = {quo_reg[30:0], ~diff[33]};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = 32'd0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

/* src/lzrc_sym_dec.sv */
// Adaptive order-1 range symbol decoder with frequency and total memories.
// Depends on lzrc_pkg and lzrc_div.
module lzrc_sym_dec (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear_en,
    input  logic [15:0]        clear_addr,
    input  logic               start,
    input  lzrc_pkg::dec_req_t req,
    output logic               done,
    output lzrc_pkg::dec_res_t res
);
    import lzrc_pkg::*;

    typedef enum logic [9:0] {
        D_IDLE = 10'b0000000001,
        D_TOT  = 10'b0000000010,
        D_DIV1 = 10'b0000000100,
        D_DIV2 = 10'b0000001000,
        D_SRCH = 10'b0000010000,
        D_MUL1 = 10'b0000100000,
        D_MUL2 = 10'b0001000000,
        D_UPD  = 10'b0010000000,
        D_RSRD = 10'b0100000000,
        D_RSCL = 10'b1000000000
    } dstate_t;

    logic [15:0] freq_mem [FREQ_DEPTH];
    logic [15:0] tot_mem  [CTX_COUNT];

    dstate_t     state_reg, state_next;
    logic [7:0]  ctx_reg, ctx_next;
    logic [31:0] diff_reg, diff_next;
    logic [31:0] low_reg, low_next;
    logic [31:0] width_reg, width_next;
    logic [31:0] target_reg, target_next;
    logic [15:0] total_reg, total_next;
    logic [7:0]  k_reg, k_next;
    logic [7:0]  sym_reg, sym_next;
    logic [23:0] cum_reg, cum_next;
    logic [15:0] fk_reg, fk_next;
    logic [31:0] prod_reg, prod_next;
    logic [15:0] sum_reg, sum_next;
    logic        done_reg, done_next;
    logic        ok_reg, ok_next;

    logic        freq_we;
    logic [15:0] freq_wa, freq_wd, freq_ra, freq_rdata;
    logic        tot_we;
    logic [7:0]  tot_wa, tot_ra;
    logic [15:0] tot_wd, tot_rdata;

    logic        div_start, div_done;
    logic [31:0] div_dividend, div_divisor, div_q;

    logic [23:0] cum_sum;
    logic [15:0] total_inc, halved, sum_add;
    logic [31:0] mul_b;
    logic [63:0] mul_out;

    lzrc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign cum_sum   = cum_reg + {8'd0, freq_rdata};
    assign total_inc = total_reg + 16'd1;
    assign halved    = {1'b0, freq_rdata[15:1]} | {15'd0, freq_rdata[0]};
    assign sum_add   = sum_reg + halved;
    assign mul_b     = (state_reg == D_MUL1) ? {8'd0, cum_reg} : {16'd0, fk_reg};
    assign mul_out   = width_reg * mul_b;

    always_comb
    begin
        state_next   = state_reg;
        ctx_next     = ctx_reg;
        diff_next    = diff_reg;
        low_next     = low_reg;
        width_next   = width_reg;
        target_next  = target_reg;
        total_next   = total_reg;
        k_next       = k_reg;
        sym_next     = sym_reg;
        cum_next     = cum_reg;
        fk_next      = fk_reg;
        prod_next    = prod_reg;
        sum_next     = sum_reg;
        done_next    = 1'b0;
        ok_next      = ok_reg;
        freq_we      = 1'b0;
        freq_wa      = {ctx_reg, k_reg};
        freq_wd      = FREQ_INIT;
        freq_ra      = {ctx_reg, k_reg + 8'd1};
        tot_we       = 1'b0;
        tot_wa       = ctx_reg;
        tot_wd       = CTX_TOTAL_INIT;
        tot_ra       = req.ctx;
        div_start    = 1'b0;
        div_dividend = width_reg;
        div_divisor  = {16'd0, tot_rdata};

        unique case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    ctx_next   = req.ctx;
                    diff_next  = req.code - req.low;
                    low_next   = req.low;
                    width_next = req.width;
                    state_next = D_TOT;
                end
            end
            D_TOT:
            begin
                total_next = tot_rdata;
                if (tot_rdata == 16'd0)
                begin
                    ok_next    = 1'b0;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = D_DIV1;
                end
            end
            D_DIV1:
            begin
                if (div_done)
                begin
                    // The step replaces the width even if decoding fails later.
                    width_next = div_q;
                    if (div_q == 32'd0)
                    begin
                        ok_next    = 1'b0;
                        done_next  = 1'b1;
                        state_next = D_IDLE;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = diff_reg;
                        div_divisor  = div_q;
                        state_next   = D_DIV2;
                    end
                end
            end
            D_DIV2:
            begin
                div_dividend = diff_reg;
                div_divisor  = width_reg;
                if (div_done)
                begin
                    target_next = div_q;
                    if (div_q >= {16'd0, total_reg})
                    begin
                        ok_next    = 1'b0;
                        done_next  = 1'b1;
                        state_next = D_IDLE;
                    end
                    else
                    begin
                        freq_ra    = {ctx_reg, 8'd0};
                        k_next     = 8'd0;
                        cum_next   = 24'd0;
                        state_next = D_SRCH;
                    end
                end
            end
            D_SRCH:
            begin
                if ({8'd0, cum_sum} > target_reg)
                begin
                    fk_next    = freq_rdata;
                    sym_next   = k_reg;
                    state_next = D_MUL1;
                end
                else if (k_reg == 8'hff)
                begin
                    ok_next    = 1'b0;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    k_next   = k_reg + 8'd1;
                    cum_next = cum_sum;
                end
            end
            D_MUL1:
            begin
                prod_next  = mul_out[31:0];
                state_next = D_MUL2;
            end
            D_MUL2:
            begin
                low_next   = low_reg + prod_reg;
                prod_next  = mul_out[31:0];
                state_next = D_UPD;
            end
            D_UPD:
            begin
                width_next = prod_reg;
                freq_we    = 1'b1;
                freq_wa    = {ctx_reg, sym_reg};
                freq_wd    = fk_reg + 16'd1;
                if (total_inc != 16'd0)
                begin
                    tot_we     = 1'b1;
                    tot_wd     = total_inc;
                    ok_next    = 1'b1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
                else
                begin
                    state_next = D_RSRD;
                end
            end
            D_RSRD:
            begin
                freq_ra    = {ctx_reg, 8'd0};
                k_next     = 8'd0;
                sum_next   = 16'd0;
                state_next = D_RSCL;
            end
            D_RSCL:
            begin
                freq_we  = 1'b1;
                freq_wd  = halved;
                sum_next = sum_add;
                k_next   = k_reg + 8'd1;
                if (k_reg == 8'hff)
                begin
                    tot_we     = 1'b1;
                    tot_wd     = sum_add;
                    ok_next    = 1'b1;
                    done_next  = 1'b1;
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase

        if (clear_en)
        begin
            freq_we = 1'b1;
            freq_wa = clear_addr;
            freq_wd = FREQ_INIT;
            tot_we  = 1'b1;
            tot_wa  = clear_addr[7:0];
            tot_wd  = CTX_TOTAL_INIT;
        end
    end

    always_ff @(posedge clk)
    begin
        if (freq_we)
        begin
            freq_mem[freq_wa] <= freq_wd;
        end
        freq_rdata <= freq_mem[freq_ra];
    end

    always_ff @(posedge clk)
    begin
        if (tot_we)
        begin
            tot_mem[tot_wa] <= tot_wd;
        end
        tot_rdata <= tot_mem[tot_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg    <= ctx_next;
        diff_reg   <= diff_next;
        low_reg    <= low_next;
        width_reg  <= width_next;
        target_reg <= target_next;
        total_reg  <= total_next;
        k_reg      <= k_next;
        sym_reg    <= sym_next;
        cum_reg    <= cum_next;
        fk_reg     <= fk_next;
        prod_reg   <= prod_next;
        sum_reg    <= sum_next;
        ok_reg     <= ok_next;
    end

    assign done      = done_reg;
    assign res.ok    = ok_reg;
    assign res.sym   = sym_reg;
    assign res.low   = low_reg;
    assign res.width = width_reg;
endmodule

/* dv/lz_range_coded_decompressor_tb.sv */
// Testbench for the range-coded LZ decompressor: feeds compressed bytes and requests,
// predicts every result word with its own decoder model and checks it in order.
// Depends on lzrc_pkg and the lz_range_coded_decompressor RTL.
`timescale 1ns / 1ps
module lz_range_coded_decompressor_tb;
    import lzrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 300000;

    typedef struct {
        logic [7:0] data;
        status_t    st;
    } dec_word_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic [0:0] s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;

    // Decoder model state.
    logic [15:0] mdl_freq [FREQ_DEPTH];
    logic [15:0] mdl_total [CTX_COUNT];
    logic [7:0]  mdl_win [WIN_DEPTH];
    logic [31:0] mdl_low, mdl_code, mdl_width;
    logic [2:0]  mdl_preload;
    logic [7:0]  mdl_flags, mdl_mask;
    logic [7:0]  mdl_fields [3];
    logic [1:0]  mdl_phase;
    logic [8:0]  mdl_copy_cnt;
    logic [15:0] mdl_copy_src;
    logic        mdl_run;
    logic [15:0] mdl_wpos;
    logic        mdl_ended;

    dec_word_t expected_out[$];
    int        errors;
    int        status_seen [8];
    int        idle_cycles;
    int        out_stall;

    lz_range_coded_decompressor u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Normalization is pending when the code sits below the interval, the interval's
    // top bytes are settled, or the width has shrunk too far.
    function automatic logic norm_pending();
        logic [31:0] hi;
        hi = mdl_low + mdl_width;
        return (mdl_code < mdl_low) || ((mdl_low ^ hi) < TOP_LIMIT)
            || (mdl_width < BOTTOM_LIMIT);
    endfunction

    function automatic status_t dec_symbol(input logic [7:0] ctx, output logic [7:0] sym);
        logic [31:0] total, step, target, cum, fk;
        logic [15:0] nt, idx;
        int          k;
        logic        found;
        sym = 8'h00;
        if (norm_pending())
            return ST_NEED;
        total = {16'h0, mdl_total[ctx]};
        if (total == 0)
            return ST_ERROR;
        step = mdl_width / total;
        mdl_width = step;
        if (step == 0)
            return ST_ERROR;
        target = (mdl_code - mdl_low) / step;
        if (target >= total)
            return ST_ERROR;
        cum = 0;
        found = 1'b0;
        idx = 16'h0;
        for (k = 0; k < 256 && !found; k++) begin
            idx = {ctx, k[7:0]};
            cum = cum + {16'h0, mdl_freq[idx]};
            if (cum > target)
                found = 1'b1;
        end
        if (!found)
            return ST_ERROR;
        fk = {16'h0, mdl_freq[idx]};
        mdl_low = mdl_low + (cum - fk) * step;
        mdl_width = step * fk;
        mdl_freq[idx] = mdl_freq[idx] + 16'd1;
        sym = idx[7:0];
        nt = total[15:0] + 16'd1;
        if (nt == 16'h0) begin
            // The context total wrapped: halve every count, keeping odd ones nonzero.
            for (k = 0; k < 256; k++) begin
                idx = {ctx, k[7:0]};
                mdl_freq[idx] = (mdl_freq[idx] >> 1) | (mdl_freq[idx] & 16'd1);
                nt = nt + mdl_freq[idx];
            end
        end
        mdl_total[ctx] = nt;
        return ST_TAKEN;
    endfunction

    function automatic status_t produce_byte(output logic [7:0] b);
        logic [7:0]  sym;
        logic [15:0] off;
        status_t     r;
        b = 8'h00;
        while (1) begin
            if (mdl_copy_cnt != 0) begin
                if (mdl_run) begin
                    b = mdl_copy_src[7:0];
                end else begin
                    b = mdl_win[mdl_copy_src];
                    mdl_copy_src = mdl_copy_src + 16'd1;
                end
                mdl_win[mdl_wpos] = b;
                mdl_wpos = mdl_wpos + 16'd1;
                mdl_copy_cnt = mdl_copy_cnt - 9'd1;
                return ST_BYTE;
            end
            if (mdl_mask != 8'h00) begin
                if (mdl_flags[7]) begin
                    r = dec_symbol(mdl_win[mdl_wpos - 16'd1], sym);
                    if (r != ST_TAKEN)
                        return r;
                    mdl_copy_src = {mdl_copy_src[15:8], sym};
                    mdl_copy_cnt = 9'd1;
                    mdl_run = 1'b1;
                end else begin
                    while (mdl_phase < 2'd3) begin
                        r = dec_symbol({6'h0, mdl_phase} + 8'd1, sym);
                        if (r == ST_NEED)
                            return r;
                        if (r != ST_TAKEN) begin
                            mdl_phase = 2'd0;
                            return r;
                        end
                        mdl_fields[mdl_phase] = sym;
                        mdl_phase = mdl_phase + 2'd1;
                    end
                    mdl_phase = 2'd0;
                    off = {mdl_fields[2], mdl_fields[1]};
                    mdl_run = 1'b1;
                    if (off == END_OFFSET) begin
                        mdl_copy_cnt = 9'd0;
                        mdl_copy_src = off;
                        mdl_ended = 1'b1;
                        return ST_END;
                    end
                    mdl_copy_cnt = MIN_RUN + {1'b0, mdl_fields[0]};
                    if (off > END_OFFSET) begin
                        mdl_copy_src = ~off + mdl_wpos + COPY_BIAS;
                        mdl_run = 1'b0;
                    end else begin
                        mdl_copy_src = off;
                    end
                end
                mdl_flags = mdl_flags << 1;
                mdl_mask = mdl_mask << 1;
            end else begin
                r = dec_symbol(8'h00, sym);
                if (r != ST_TAKEN)
                    return r;
                mdl_flags = sym;
                mdl_mask = FLAG_FULL;
            end
        end
        return ST_ERROR;
    endfunction

    function automatic dec_word_t predict_word(input logic op, input logic [7:0] in_b);
        dec_word_t w;
        logic [7:0] b;
        w.data = 8'h00;
        if (op == OP_FEED) begin
            if (mdl_preload < PRELOAD_BYTES) begin
                mdl_code = {mdl_code[23:0], in_b};
                mdl_preload = mdl_preload + 3'd1;
                w.st = ST_TAKEN;
            end else if (mdl_ended || !norm_pending()) begin
                w.st = ST_REFUSED;
            end else begin
                mdl_code = {mdl_code[23:0], in_b};
                mdl_low = mdl_low << 8;
                mdl_width = mdl_width << 8;
                if (mdl_width + mdl_low < mdl_low)
                    mdl_width = ~mdl_low;
                w.st = ST_TAKEN;
            end
        end else if (mdl_ended) begin
            w.st = ST_END;
        end else if (mdl_preload < PRELOAD_BYTES) begin
            w.st = ST_NEED;
        end else begin
            w.st = produce_byte(b);
            if (w.st == ST_BYTE)
                w.data = b;
        end
        return w;
    endfunction

    // Sends one word after a random gap; the prediction is made at acceptance.
    task automatic send_word(input logic op, input logic [7:0] in_b);
        int gap;
        gap = $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= in_b;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_out.push_back(predict_word(op, in_b));
        @(negedge clk);
    endtask

    // Well-formed traffic: feed exactly when the decoder is starved, else request.
    task automatic send_stream_word();
        if (mdl_preload < PRELOAD_BYTES || (!mdl_ended && norm_pending()))
            send_word(OP_FEED, 8'($urandom));
        else
            send_word(OP_REQUEST, 8'($urandom));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_out.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_preload();
        send_word(OP_REQUEST, 8'h00);   // before any preload byte
        send_word(OP_FEED, 8'hff);
        send_word(OP_FEED, 8'h00);
        send_word(OP_REQUEST, 8'hff);   // preload still incomplete
        send_word(OP_FEED, 8'h80);
        send_word(OP_FEED, 8'h01);
        send_word(OP_FEED, 8'h5a);      // nothing pending: refused
    endtask

    task automatic test_directed_decode();
        int i;
        for (i = 0; i < 16; i++)
            send_stream_word();
        send_word(OP_FEED, 8'h00);
        send_word(OP_REQUEST, 8'h00);
    endtask

    task automatic test_random_mix(input int count);
        int i;
        for (i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) != 0)
                send_stream_word();
            else
                send_word(1'($urandom), 8'($urandom));
            if (i == count / 2)
                wait_drained();
        end
    endtask

    // Ready draws a fresh stall after every accepted result word.
    always @(negedge clk) begin
        if (out_stall > 0) begin
            m_axis_tready <= 1'b0;
            out_stall <= out_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        dec_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            out_stall <= $urandom_range(0, 10);
            status_seen[m_axis_tuser]++;
            if (expected_out.size() == 0) begin
                $error("unexpected result word: status %0d data %0h", m_axis_tuser,
                       m_axis_tdata);
                errors++;
            end else begin
                w = expected_out.pop_front();
                if (m_axis_tuser !== w.st) begin
                    $error("status: expected %0d actual %0d", w.st, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== w.data) begin
                    $error("out_byte: expected %0h actual %0h", w.data, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted word; covers the clearing pass too.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_out.size());
            $display("lz_range_coded_decompressor regression: fail");
            $finish;
        end
    end

    initial begin
        int i;
        errors = 0;
        idle_cycles = 0;
        out_stall = 0;
        for (i = 0; i < 8; i++)
            status_seen[i] = 0;
        for (i = 0; i < FREQ_DEPTH; i++)
            mdl_freq[i] = FREQ_INIT;
        for (i = 0; i < CTX_COUNT; i++)
            mdl_total[i] = CTX_TOTAL_INIT;
        for (i = 0; i < WIN_DEPTH; i++)
            mdl_win[i] = WIN_INIT;
        mdl_low = 0;
        mdl_code = 0;
        mdl_width = 32'hffff_ffff;
        mdl_preload = 0;
        mdl_flags = 0;
        mdl_mask = 0;
        for (i = 0; i < 3; i++)
            mdl_fields[i] = 0;
        mdl_phase = 0;
        mdl_copy_cnt = 0;
        mdl_copy_src = 16'hffff;
        mdl_run = 0;
        mdl_wpos = 0;
        mdl_ended = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_preload();
        test_directed_decode();
        test_random_mix(500);

        wait_drained();
        repeat (50) @(posedge clk);
        $display("covered: %0d taken, %0d bytes, %0d need-input, %0d end, %0d error, %0d refused",
                 status_seen[ST_TAKEN], status_seen[ST_BYTE], status_seen[ST_NEED],
                 status_seen[ST_END], status_seen[ST_ERROR], status_seen[ST_REFUSED]);
        $display("final model window position %0h, ended %0b", mdl_wpos, mdl_ended);
        if (errors == 0 && expected_out.size() == 0)
            $display("lz_range_coded_decompressor regression: pass");
        else
            $display("lz_range_coded_decompressor regression: fail");
        $finish;
    end

endmodule
